[rtl/dda_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dda_pkg
// Shared types and constants of the decimal digit array arithmetic unit.
// ----------------------------------------------------------------------------
package dda_pkg;

    localparam int RES_DEPTH = 32;          // result digits kept
    localparam int DEC_BASE  = 10;
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    // raw op codes on the input side
    localparam logic [1:0] OPC_SUB = 2'd1;
    localparam logic [1:0] OPC_MUL = 2'd2;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_CALC,
        ST_EMIT
    } back_state_t;

    // one classified digit pair between front and back
    typedef struct packed {
        op_t        op;     // op held for the whole run
        logic [3:0] a;
        logic [3:0] b;
        logic       last;
        logic       keep;   // pair is stored (count below the limit)
        logic       ovf;    // pairs were dropped so far in this run
    } entry_t;

    // quotient by ten for values below 128
    function automatic logic [3:0] div10(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'(205);
        return p[14:11];
    endfunction

endpackage
`default_nettype wire

[rtl/dda_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dda_front
// Intake: clamps digits, holds the op of the run, counts pairs, drops the
// pairs beyond the limit and tags each stored pair for the back end.
// ----------------------------------------------------------------------------
module dda_front #(
    parameter int MAX_DIGITS = 16
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_axis_tvalid,
    output logic                 s_axis_tready,
    input  wire logic [7:0]      s_axis_tdata,   // [3:0] digit_a, [7:4] digit_b
    input  wire logic            s_axis_tlast,   // last_digit
    input  wire logic [1:0]      s_axis_tuser,   // [1:0] op
    output logic                 q_push,
    output dda_pkg::entry_t      q_entry,
    input  wire logic            q_full
);

    localparam int NW = $clog2(MAX_DIGITS + 1);

    logic [NW-1:0]   cnt_reg, cnt_next;
    dda_pkg::op_t    op_reg, op_next;
    logic            ovf_reg, ovf_next;

    logic            beat;
    logic            keep;
    dda_pkg::op_t    op_in;
    dda_pkg::op_t    op_eff;
    logic            ovf_eff;

    function automatic logic [3:0] clamp_digit(input logic [3:0] v);
        return (v > dda_pkg::DIGIT_MAX) ? dda_pkg::DIGIT_MAX : v;
    endfunction

    always_comb
    begin
        case (s_axis_tuser)
            dda_pkg::OPC_SUB: op_in = dda_pkg::OP_SUB;
            dda_pkg::OPC_MUL: op_in = dda_pkg::OP_MUL;
            default:          op_in = dda_pkg::OP_ADD;   // op three adds too
        endcase
    end

    assign s_axis_tready = !q_full;
    assign beat    = s_axis_tvalid && s_axis_tready;
    assign keep    = cnt_reg < NW'(MAX_DIGITS);
    assign op_eff  = (cnt_reg == '0) ? op_in : op_reg;
    assign ovf_eff = ovf_reg || !keep;

    // dropped pairs are not queued unless they close the run
    assign q_push        = beat && (keep || s_axis_tlast);
    assign q_entry.op    = op_eff;
    assign q_entry.a     = clamp_digit(s_axis_tdata[3:0]);
    assign q_entry.b     = clamp_digit(s_axis_tdata[7:4]);
    assign q_entry.last  = s_axis_tlast;
    assign q_entry.keep  = keep;
    assign q_entry.ovf   = ovf_eff;

    always_comb
    begin
        cnt_next = cnt_reg;
        op_next  = op_reg;
        ovf_next = ovf_reg;
        if (beat)
        begin
            if (s_axis_tlast)
            begin
                cnt_next = '0;
                op_next  = dda_pkg::OP_ADD;
                ovf_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + NW'(keep);
                op_next  = op_eff;
                ovf_next = ovf_eff;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            op_reg  <= dda_pkg::OP_ADD;
            ovf_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            op_reg  <= op_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule
`default_nettype wire

[rtl/dda_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dda_fifo
// Two-entry queue of classified digit pairs between front and back.
// ----------------------------------------------------------------------------
module dda_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire dda_pkg::entry_t  wr_entry,
    output logic                  full,
    input  wire logic             pop,
    output dda_pkg::entry_t       rd_entry,
    output logic                  empty
);

    dda_pkg::entry_t mem [2];
    logic            wr_ptr_reg, wr_ptr_next;
    logic            rd_ptr_reg, rd_ptr_next;
    logic [1:0]      cnt_reg, cnt_next;

    assign full     = cnt_reg == 2'd2;
    assign empty    = cnt_reg == 2'd0;
    assign rd_entry = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

[rtl/dda_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dda_back
// Execution: stores the operand digits, runs the add, subtract or schoolbook
// multiply one digit step per cycle, then sends the result digits most
// significant first with leading zeros skipped.
// ----------------------------------------------------------------------------
module dda_back #(
    parameter int MAX_DIGITS = 16
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire dda_pkg::entry_t  q_entry,
    input  wire logic             q_empty,
    output logic                  q_pop,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [7:0]            m_axis_tdata,   // [3:0] result_digit, [7:4] zero
    output logic                  m_axis_tlast,   // is_last
    output logic [1:0]            m_axis_tuser    // [0] borrow_out, [1] overflow
);

    localparam int NW = $clog2(MAX_DIGITS + 1);
    localparam int AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int RW = $clog2(dda_pkg::RES_DEPTH);
    localparam int KW = RW + 1;

    dda_pkg::back_state_t state_reg, state_next;

    logic [3:0]  a_mem [MAX_DIGITS];
    logic [3:0]  b_mem [MAX_DIGITS];
    logic [3:0]  w_mem [dda_pkg::RES_DEPTH];
    logic [dda_pkg::RES_DEPTH-1:0] wv_reg, wv_next;

    logic [NW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] i_reg, i_next;
    logic [NW-1:0] j_reg, j_next;
    logic [3:0]    c_reg, c_next;
    dda_pkg::op_t  op_reg, op_next;
    logic          ovf_reg, ovf_next;
    logic          bout_reg, bout_next;
    logic [RW-1:0] eidx_reg, eidx_next;
    logic          started_reg, started_next;

    logic          ov_reg, ov_next;
    logic [3:0]    od_reg, od_next;
    logic          ol_reg, ol_next;
    logic          ob_reg, ob_next;
    logic          oo_reg, oo_next;

    // datapath
    logic          jn;
    logic [NW-1:0] ja, ia;
    logic [3:0]    a_d, b_d, bi;
    logic [KW-1:0] k;
    logic          k_in;
    logic [RW-1:0] rd_idx;
    logic          rd_ok;
    logic [3:0]    rdat;
    logic [6:0]    prod;
    logic [6:0]    t;
    logic [3:0]    q10;
    logic [6:0]    r10;
    logic [4:0]    d;
    logic [3:0]    step_digit;
    logic [3:0]    step_carry;
    logic          calc_last;
    logic [6:0]    lenx;
    logic [RW-1:0] lm1;
    logic          out_free;
    logic          show;
    logic          a_we;
    logic          w_we;

    assign jn   = j_reg == n_reg;
    assign ja   = n_reg - NW'(1) - j_reg;
    assign ia   = n_reg - NW'(1) - i_reg;
    assign a_d  = jn ? 4'd0 : a_mem[ja[AW-1:0]];
    assign b_d  = jn ? 4'd0 : b_mem[ja[AW-1:0]];
    assign bi   = b_mem[ia[AW-1:0]];
    assign k    = KW'(i_reg) + KW'(j_reg);
    assign k_in = k < KW'(dda_pkg::RES_DEPTH);

    assign rd_idx = (state_reg == dda_pkg::ST_EMIT) ? eidx_reg : k[RW-1:0];
    assign rd_ok  = (state_reg == dda_pkg::ST_EMIT) || k_in;
    assign rdat   = (rd_ok && wv_reg[rd_idx]) ? w_mem[rd_idx] : 4'd0;

    assign prod = (op_reg == dda_pkg::OP_MUL) ? 7'(a_d) * 7'(bi) : 7'(a_d) + 7'(b_d);
    assign t    = 7'(rdat) + prod + 7'(c_reg);
    assign q10  = dda_pkg::div10(t);
    assign r10  = t - 7'(q10) * 7'(dda_pkg::DEC_BASE);
    assign d    = 5'(a_d) + 5'(dda_pkg::DEC_BASE) - 5'(b_d) - 5'(c_reg);

    always_comb
    begin
        if (op_reg == dda_pkg::OP_SUB)
        begin
            if (d >= 5'(dda_pkg::DEC_BASE))
            begin
                step_digit = 4'(d - 5'(dda_pkg::DEC_BASE));
                step_carry = 4'd0;
            end
            else
            begin
                step_digit = d[3:0];
                step_carry = 4'd1;
            end
        end
        else
        begin
            step_digit = r10[3:0];
            step_carry = q10;
        end
    end

    always_comb
    begin
        case (op_reg)
            dda_pkg::OP_SUB:
            begin
                calc_last = j_reg == n_reg - NW'(1);
                lenx      = 7'(n_reg);
            end
            dda_pkg::OP_MUL:
            begin
                calc_last = (i_reg == n_reg - NW'(1)) && jn;
                lenx      = 7'(n_reg) << 1;
            end
            default:
            begin
                calc_last = jn;
                lenx      = 7'(n_reg) + 7'd1;
            end
        endcase
    end

    // digits past the kept range are dropped
    assign lm1 = (lenx > 7'(dda_pkg::RES_DEPTH)) ? RW'(dda_pkg::RES_DEPTH - 1)
                                                : RW'(lenx - 7'd1);

    assign out_free = !ov_reg || m_axis_tready;
    assign show     = started_reg || (rdat != 4'd0) || (eidx_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dda_pkg::ST_LOAD:
            begin
                if (!q_empty && q_entry.last)
                begin
                    state_next = dda_pkg::ST_CALC;
                end
            end
            dda_pkg::ST_CALC:
            begin
                if (calc_last)
                begin
                    state_next = dda_pkg::ST_EMIT;
                end
            end
            dda_pkg::ST_EMIT:
            begin
                if (out_free && (eidx_reg == '0))
                begin
                    state_next = dda_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = dda_pkg::ST_LOAD;
            end
        endcase
    end

    // outputs and register updates
    always_comb
    begin
        q_pop        = 1'b0;
        a_we         = 1'b0;
        w_we         = 1'b0;
        wv_next      = wv_reg;
        cnt_next     = cnt_reg;
        n_next       = n_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        c_next       = c_reg;
        op_next      = op_reg;
        ovf_next     = ovf_reg;
        bout_next    = bout_reg;
        eidx_next    = eidx_reg;
        started_next = started_reg;
        ov_next      = ov_reg && !m_axis_tready;
        od_next      = od_reg;
        ol_next      = ol_reg;
        ob_next      = ob_reg;
        oo_next      = oo_reg;
        case (state_reg)
            dda_pkg::ST_LOAD:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    a_we  = q_entry.keep;
                    if (q_entry.last)
                    begin
                        n_next   = cnt_reg + NW'(q_entry.keep);
                        cnt_next = '0;
                        op_next  = q_entry.op;
                        ovf_next = q_entry.ovf;
                        i_next   = '0;
                        j_next   = '0;
                        c_next   = 4'd0;
                        wv_next  = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + NW'(q_entry.keep);
                    end
                end
            end
            dda_pkg::ST_CALC:
            begin
                w_we   = k_in;
                if (k_in)
                begin
                    wv_next[k[RW-1:0]] = 1'b1;
                end
                c_next = step_carry;
                if (jn)
                begin
                    j_next = '0;
                    i_next = i_reg + NW'(1);
                    c_next = 4'd0;
                end
                else
                begin
                    j_next = j_reg + NW'(1);
                end
                if (calc_last)
                begin
                    eidx_next    = lm1;
                    started_next = 1'b0;
                    bout_next    = (op_reg == dda_pkg::OP_SUB) && step_carry[0];
                end
            end
            dda_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    if (show)
                    begin
                        ov_next      = 1'b1;
                        od_next      = rdat;
                        ol_next      = eidx_reg == '0;
                        ob_next      = bout_reg;
                        oo_next      = ovf_reg;
                        started_next = 1'b1;
                    end
                    if (eidx_reg != '0)
                    begin
                        eidx_next = eidx_reg - RW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[cnt_reg[AW-1:0]] <= q_entry.a;
            b_mem[cnt_reg[AW-1:0]] <= q_entry.b;
        end
        if (w_we)
        begin
            w_mem[k[RW-1:0]] <= step_digit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= dda_pkg::ST_LOAD;
            wv_reg      <= '0;
            cnt_reg     <= '0;
            n_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            c_reg       <= 4'd0;
            op_reg      <= dda_pkg::OP_ADD;
            ovf_reg     <= 1'b0;
            bout_reg    <= 1'b0;
            eidx_reg    <= '0;
            started_reg <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wv_reg      <= wv_next;
            cnt_reg     <= cnt_next;
            n_reg       <= n_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            c_reg       <= c_next;
            op_reg      <= op_next;
            ovf_reg     <= ovf_next;
            bout_reg    <= bout_next;
            eidx_reg    <= eidx_next;
            started_reg <= started_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        od_reg <= od_next;
        ol_reg <= ol_next;
        ob_reg <= ob_next;
        oo_reg <= oo_next;
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {4'd0, od_reg};
    assign m_axis_tlast  = ol_reg;
    assign m_axis_tuser  = {oo_reg, ob_reg};

endmodule
`default_nettype wire

[rtl/decimal_digit_array_arithmetic.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_digit_array_arithmetic
// Multi-digit decimal add, subtract and multiply on operands streamed as
// digit pairs, most significant first; result digits streamed back.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                      | tlast       | tuser
//  s_axis   | in  | [3:0] digit_a [7:4] digit_b | last_digit  | [1:0] op
//  m_axis   | out | [3:0] result_digit         | is_last     | [0] borrow_out
//           |     |                            |             | [1] overflow
//
//  Digit pairs are taken one a cycle while the two-entry queue has room, and
//  stored one a cycle while the back end loads. The last pair starts the digit
//  step unit, one step a cycle: n+1 steps for add, n for subtract, n*(n+1) for
//  multiply (n digit pairs); then the result digits are scanned (at most 32)
//  as the output takes them. No new pair is stored until the last result digit
//  is sent; multiply is paced by the single digit-product step unit.
//  Reset clears all control state; no clearing pass is needed.
//  Either side may stall at any time; the output register holds its beat.
// ----------------------------------------------------------------------------
module decimal_digit_array_arithmetic #(
    parameter int MAX_DIGITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [3:0] digit_a, [7:4] digit_b
    input  wire logic        s_axis_tlast,   // last_digit
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] op
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [3:0] result_digit, [7:4] zero
    output logic             m_axis_tlast,   // is_last
    output logic [1:0]       m_axis_tuser    // [0] borrow_out, [1] overflow
);

    logic            q_push;
    logic            q_full;
    logic            q_pop;
    logic            q_empty;
    dda_pkg::entry_t q_wr_entry;
    dda_pkg::entry_t q_rd_entry;

    dda_front #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .q_push        (q_push),
        .q_entry       (q_wr_entry),
        .q_full        (q_full)
    );

    dda_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_wr_entry),
        .full     (q_full),
        .pop      (q_pop),
        .rd_entry (q_rd_entry),
        .empty    (q_empty)
    );

    dda_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_entry       (q_rd_entry),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // queue never written when full nor read when empty
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("queue push while full");

    a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue pop while empty");

    // every sent beat is a decimal digit
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[3:0] <= 4'd9))
        else $error("result digit above nine");

endmodule
`default_nettype wire

[verif/decimal_digit_array_arithmetic_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_digit_array_arithmetic_test
// Streams decimal operands as digit pairs into the unit and checks every
// result digit, last flag, borrow and overflow flag against a digit-level
// model kept in the bench. Directed cases cover carry ripple, borrow, zero
// suppression, digit saturation, op three, op on later pairs and dropped
// pairs. Random operations follow under three back-pressure mixes.
// ----------------------------------------------------------------------------
module decimal_digit_array_arithmetic_test;

    localparam int MAX_DIGITS  = 16;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 400;   // worst multiply plus a full digit scan

    typedef struct packed {
        logic [3:0] digit;
        logic       last;
        logic       borrow;
        logic       ovf;
    } result_beat_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;     // [3:0] digit_a, [7:4] digit_b
    logic       s_axis_tlast = 1'b0;   // last_digit
    logic [1:0] s_axis_tuser = '0;     // [1:0] op
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [3:0] result_digit, [7:4] zero
    logic       m_axis_tlast;          // is_last
    logic [1:0] m_axis_tuser;          // [0] borrow_out, [1] overflow

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int error_count   = 0;
    int cycle_count   = 0;

    // bench copy of the operand stores and run control
    logic [3:0] a_store [MAX_DIGITS];
    logic [3:0] b_store [MAX_DIGITS];
    int         pair_count = 0;
    logic [1:0] run_op = dda_pkg::OP_ADD;
    logic       run_ovf = 1'b0;

    result_beat_t expected_digits [$];

    decimal_digit_array_arithmetic #(
        .MAX_DIGITS(MAX_DIGITS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tlast (s_axis_tlast),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast),
        .m_axis_tuser (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);

    function automatic logic [3:0] sat_digit(input logic [3:0] d);
        return (d > dda_pkg::DIGIT_MAX) ? dda_pkg::DIGIT_MAX : d;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // Stores each pair; digit-serial arithmetic on the stored operands runs when the last pair lands.
    task automatic compute_digits(input logic [1:0] op, input logic [3:0] da,
                                  input logic [3:0] db, input logic last);
        int la [MAX_DIGITS];
        int lb [MAX_DIGITS];
        int work [2*MAX_DIGITS+2];
        int n;
        int len;
        int top;
        int carry;
        int t;
        int brw;
        result_beat_t beat;

        if (pair_count == 0)
            run_op = op;
        if (pair_count < MAX_DIGITS)
        begin
            a_store[pair_count] = sat_digit(da);
            b_store[pair_count] = sat_digit(db);
            pair_count++;
        end
        else
            run_ovf = 1'b1;
        if (!last)
            return;

        n = pair_count;
        for (int i = 0; i < n; i++)
        begin
            la[i] = a_store[n-1-i];
            lb[i] = b_store[n-1-i];
        end
        foreach (work[k])
            work[k] = 0;
        brw = 0;

        if (run_op == dda_pkg::OP_SUB)
        begin
            for (int i = 0; i < n; i++)
            begin
                t = lb[i] + brw;
                if (la[i] >= t)
                begin
                    work[i] = la[i] - t;
                    brw = 0;
                end
                else
                begin
                    work[i] = la[i] + dda_pkg::DEC_BASE - t;
                    brw = 1;
                end
            end
            len = n;
        end
        else if (run_op == dda_pkg::OP_MUL)
        begin
            for (int i = 0; i < n; i++)
            begin
                carry = 0;
                for (int j = 0; j < n; j++)
                begin
                    t = work[i+j] + la[j] * lb[i] + carry;
                    work[i+j] = t % dda_pkg::DEC_BASE;
                    carry = t / dda_pkg::DEC_BASE;
                end
                work[i+n] = carry;
            end
            len = 2 * n;
        end
        else
        begin
            // op three falls through to add
            carry = 0;
            for (int i = 0; i < n; i++)
            begin
                t = la[i] + lb[i] + carry;
                work[i] = t % dda_pkg::DEC_BASE;
                carry = t / dda_pkg::DEC_BASE;
            end
            work[n] = carry;
            len = n + 1;
        end

        if (len > dda_pkg::RES_DEPTH)
            len = dda_pkg::RES_DEPTH;
        top = 0;
        for (int i = len - 1; i >= 0; i--)
            if (work[i] != 0)
            begin
                top = i;
                break;
            end

        for (int i = top; i >= 0; i--)
        begin
            beat.digit  = work[i][3:0];
            beat.last   = (i == 0);
            beat.borrow = brw[0];
            beat.ovf    = run_ovf;
            expected_digits.push_back(beat);
        end

        pair_count = 0;
        run_op     = dda_pkg::OP_ADD;
        run_ovf    = 1'b0;
    endtask

    always @(posedge clk)
    begin : check_beats
        result_beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_digits.size() == 0)
                report_mismatch("unexpected digit", m_axis_tdata[3:0], 0);
            else
            begin
                want = expected_digits.pop_front();
                if (m_axis_tdata[3:0] !== want.digit)
                    report_mismatch("result_digit", m_axis_tdata[3:0], want.digit);
                if (m_axis_tlast !== want.last)
                    report_mismatch("is_last", m_axis_tlast, want.last);
                if (m_axis_tuser[0] !== want.borrow)
                    report_mismatch("borrow_out", m_axis_tuser[0], want.borrow);
                if (m_axis_tuser[1] !== want.ovf)
                    report_mismatch("overflow", m_axis_tuser[1], want.ovf);
            end
        end
    end

    // One digit pair; call at a rising edge, returns at the edge that took the beat.
    task automatic send_pair(input logic [1:0] op, input logic [3:0] da,
                             input logic [3:0] db, input logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {db, da};
        s_axis_tlast  <= last;
        s_axis_tuser  <= op;
        do
            @(posedge clk);
        while (!s_axis_tready);
        compute_digits(op, da, db, last);
    endtask

    function automatic logic [3:0] hex_char_digit(input byte c);
        return (c >= "A") ? 4'(c - "A" + 10) : 4'(c - "0");
    endfunction

    // Operands as hex strings, most significant first; op only counts on the
    // first pair, so later pairs carry junk in tuser.
    task automatic send_operation(input logic [1:0] op, input string a, input string b);
        logic [1:0] pair_op;
        for (int i = 0; i < a.len(); i++)
        begin
            pair_op = (i == 0) ? op : 2'($urandom_range(3));
            send_pair(pair_op, hex_char_digit(a[i]), hex_char_digit(b[i]),
                      i == a.len() - 1);
        end
    endtask

    task automatic test_add_sub;
        send_operation(dda_pkg::OP_ADD, "999", "001");   // carry through every digit
        send_operation(dda_pkg::OP_SUB, "01", "02");     // negative: ten's complement
        send_operation(dda_pkg::OP_SUB, "10", "01");     // leading zero dropped
        send_operation(dda_pkg::OP_SUB, "5", "5");       // zero result still one digit
    endtask

    task automatic test_multiply;
        send_operation(dda_pkg::OP_MUL, "0", "7");
        send_operation(dda_pkg::OP_MUL, "99", "99");
    endtask

    task automatic test_saturation_and_op3;
        send_operation(2'd3, "FA", "CB");           // digits above nine, op three
        send_operation(dda_pkg::OP_ADD, "8", "F");
    endtask

    task automatic test_dropped_pairs;
        // 16 nines squared fills all 32 result digits; the 17th pair is dropped
        send_operation(dda_pkg::OP_MUL, "99999999999999990", "99999999999999995");
    endtask

    task automatic test_random_stream(input int item_target);
        int sent;
        int len;
        int roll;
        logic [1:0] op;
        logic [1:0] pair_op;
        logic [3:0] da;
        logic [3:0] db;
        sent = 0;
        while (sent < item_target)
        begin
            roll = $urandom_range(99);
            if (roll < 70)
                len = $urandom_range(5, 1);
            else if (roll < 90)
                len = $urandom_range(MAX_DIGITS, 6);
            else
                len = $urandom_range(MAX_DIGITS + 3, MAX_DIGITS + 1);
            op = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
            for (int i = 0; i < len; i++)
            begin
                da = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10))
                                              : 4'($urandom_range(9));
                db = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 10))
                                              : 4'($urandom_range(9));
                pair_op = (i == 0) ? op : 2'($urandom_range(3));
                send_pair(pair_op, da, db, i == len - 1);
            end
            sent += len;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 29;
        recv_idle_pct = 74;
        test_add_sub;
        test_multiply;
        test_saturation_and_op3;
        test_dropped_pairs;
        test_random_stream(30);

        send_idle_pct = 74;
        recv_idle_pct = 29;
        test_random_stream(30);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_stream(30);

        s_axis_tvalid <= 1'b0;
        while (expected_digits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
